// ----- rtl/iafp_pkg.sv -----
// ----------------------------------------------------------------------------
// IMU angle frame parser - shared definitions
// Frame geometry, register indexes and common types.
// ----------------------------------------------------------------------------
package iafp_pkg;

    // Total bytes in one frame, header and checksum included (11..16)
    localparam int FRAME_BYTES = 11;

    // Byte position counter wide enough for the largest frame
    localparam int POS_W = 4;

    // Payload bytes kept for the result: roll, pitch, yaw, version
    localparam int PAY_FIRST = 2;
    localparam int PAY_LAST  = 9;
    localparam int PAY_BYTES = PAY_LAST - PAY_FIRST + 1;
    localparam int PAY_IDX_W = $clog2(PAY_BYTES);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEADER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_TYPE   = 1'b1;

    localparam logic [7:0] HEADER_RESET = 8'h55;
    localparam logic [7:0] TYPE_RESET   = 8'h53;

    typedef logic [7:0]        t_byte;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [15:0]       t_word;
    typedef logic [31:0]       t_count;

endpackage

// ----- rtl/iafp_rx_if.sv -----
// ----------------------------------------------------------------------------
// IMU angle frame parser - received byte channel
// One serial byte per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iafp_rx_if;

    logic           valid;
    logic           ready;
    iafp_pkg::t_byte rx_byte;

    modport source (
        output valid,
        output rx_byte,
        input  ready
    );

    modport sink (
        input  valid,
        input  rx_byte,
        output ready
    );

endinterface

// ----- rtl/iafp_res_if.sv -----
// ----------------------------------------------------------------------------
// IMU angle frame parser - frame result channel
// One parsed frame per beat, valid/ready handshake.
// ----------------------------------------------------------------------------
interface iafp_res_if;

    logic                  valid;
    logic                  ready;
    logic                  checksum_ok;
    logic signed [15:0]    roll_count;
    logic signed [15:0]    pitch_count;
    logic signed [15:0]    yaw_count;
    iafp_pkg::t_word       version_word;
    iafp_pkg::t_count      good_frames;
    iafp_pkg::t_count      bad_frames;

    modport source (
        output valid,
        output checksum_ok,
        output roll_count,
        output pitch_count,
        output yaw_count,
        output version_word,
        output good_frames,
        output bad_frames,
        input  ready
    );

    modport sink (
        input  valid,
        input  checksum_ok,
        input  roll_count,
        input  pitch_count,
        input  yaw_count,
        input  version_word,
        input  good_frames,
        input  bad_frames,
        output ready
    );

endinterface

// ----- rtl/imu_angle_frame_parser_unit.sv -----
// ----------------------------------------------------------------------------
// IMU angle frame parser
// Byte-serial parser for IMU angle frames with checksum and frame counters.
// ----------------------------------------------------------------------------
// Takes one serial byte per beat and accepts a byte every clock unless
// stalled. A frame is a header byte, an angle type byte, payload and a
// checksum byte; a wrong type byte drops the frame silently (that byte is
// never taken as a new header). When the last byte arrives the result beat
// shows the raw roll, pitch and yaw counts, the version word, a checksum flag
// and the running good/bad frame totals; it appears the cycle after the
// checksum byte. The checksum is kept as a running 8-bit sum. The result sits
// in an output register: input keeps flowing while it waits, and ready drops
// only when the checksum byte of the next frame is due and the previous
// result has still not been taken. The user writes header and type codes via
// the config port only while the parser is idle; the block does not check it.
// ----------------------------------------------------------------------------
module imu_angle_frame_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [iafp_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [iafp_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    iafp_rx_if.sink                             i_rx,
    iafp_res_if.source                          o_res
);

    typedef enum logic [1:0] {
        PH_IDLE,    // hunting for header
        PH_TYPE,    // header seen, type byte next
        PH_DATA     // collecting payload and checksum
    } t_phase;

    localparam iafp_pkg::t_pos LAST_POS = iafp_pkg::POS_W'(iafp_pkg::FRAME_BYTES - 1);
    localparam iafp_pkg::t_pos PAY_LO   = iafp_pkg::POS_W'(iafp_pkg::PAY_FIRST);
    localparam iafp_pkg::t_pos PAY_HI   = iafp_pkg::POS_W'(iafp_pkg::PAY_LAST);
    localparam iafp_pkg::t_pos POS_ONE  = iafp_pkg::POS_W'(1);
    localparam iafp_pkg::t_pos POS_TWO  = iafp_pkg::POS_W'(2);

    // Config registers
    iafp_pkg::t_byte r_header;
    iafp_pkg::t_byte r_type;

    // Parser state
    t_phase          r_phase, n_phase;
    iafp_pkg::t_pos  r_pos,   n_pos;
    iafp_pkg::t_byte r_sum,   n_sum;

    // Payload bytes of the frame in progress
    iafp_pkg::t_byte r_pay [iafp_pkg::PAY_BYTES];

    // Totals, shown directly on the result beat
    iafp_pkg::t_count r_good;
    iafp_pkg::t_count r_bad;

    // Result register
    logic               r_out_valid;
    logic               r_ok;
    iafp_pkg::t_word    r_roll;
    iafp_pkg::t_word    r_pitch;
    iafp_pkg::t_word    r_yaw;
    iafp_pkg::t_word    r_ver;

    logic                          w_last;
    logic                          w_in_ready;
    logic                          w_in_fire;
    logic                          w_done;
    logic                          w_ok;
    logic                          w_pay_we;
    iafp_pkg::t_pos                w_pay_off;
    logic [iafp_pkg::PAY_IDX_W-1:0] w_pay_idx;

    // Checksum byte is due next
    assign w_last = (r_phase == PH_DATA) && (r_pos == LAST_POS);

    // Stall only if this byte would make a second result while one waits
    assign w_in_ready = !(w_last && r_out_valid && !o_res.ready);
    assign w_in_fire  = i_rx.valid && w_in_ready;
    assign w_done     = w_in_fire && w_last;
    assign w_ok       = (i_rx.rx_byte == r_sum);

    assign w_pay_we  = w_in_fire && (r_phase == PH_DATA) &&
                       (r_pos >= PAY_LO) && (r_pos <= PAY_HI);
    assign w_pay_off = r_pos - PAY_LO;
    assign w_pay_idx = w_pay_off[iafp_pkg::PAY_IDX_W-1:0];

    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_sum   = r_sum;
        if (w_in_fire) begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_rx.rx_byte == r_header) begin
                        n_phase = PH_TYPE;
                        n_pos   = POS_ONE;
                        n_sum   = i_rx.rx_byte;
                    end
                end
                PH_TYPE: begin
                    if (i_rx.rx_byte == r_type) begin
                        n_phase = PH_DATA;
                        n_pos   = POS_TWO;
                        n_sum   = r_sum + i_rx.rx_byte;
                    end else begin
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end
                end
                PH_DATA: begin
                    if (w_last) begin
                        n_phase = PH_IDLE;
                        n_pos   = '0;
                    end else begin
                        n_pos = r_pos + POS_ONE;
                        n_sum = r_sum + i_rx.rx_byte;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                    n_pos   = '0;
                end
            endcase
        end
    end

    // Control state, config and totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header    <= iafp_pkg::HEADER_RESET;
            r_type      <= iafp_pkg::TYPE_RESET;
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_sum       <= '0;
            r_good      <= '0;
            r_bad       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    iafp_pkg::CFG_IDX_HEADER: r_header <= i_cfg_data;
                    iafp_pkg::CFG_IDX_TYPE:   r_type   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            if (w_done) begin
                r_out_valid <= 1'b1;
                if (w_ok) begin
                    r_good <= r_good + 32'd1;
                end else begin
                    r_bad <= r_bad + 32'd1;
                end
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_pay_we) begin
            r_pay[w_pay_idx] <= i_rx.rx_byte;
        end
        if (w_done) begin
            r_ok    <= w_ok;
            r_roll  <= {r_pay[1], r_pay[0]};
            r_pitch <= {r_pay[3], r_pay[2]};
            r_yaw   <= {r_pay[5], r_pay[4]};
            r_ver   <= {r_pay[7], r_pay[6]};
        end
    end

    assign i_rx.ready         = w_in_ready;
    assign o_res.valid        = r_out_valid;
    assign o_res.checksum_ok  = r_ok;
    assign o_res.roll_count   = $signed(r_roll);
    assign o_res.pitch_count  = $signed(r_pitch);
    assign o_res.yaw_count    = $signed(r_yaw);
    assign o_res.version_word = r_ver;
    assign o_res.good_frames  = r_good;
    assign o_res.bad_frames   = r_bad;

endmodule

// ----- rtl/iafp_checker.sv -----
// ----------------------------------------------------------------------------
// IMU angle frame parser - port checker
// Assertions on handshake and frame totals as seen at the ports.
// ----------------------------------------------------------------------------
module iafp_checker (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_rx_valid,
    input logic                    i_rx_ready,
    input logic                    i_res_valid,
    input logic                    i_res_ready,
    input logic                    i_checksum_ok,
    input iafp_pkg::t_count        i_good_frames,
    input iafp_pkg::t_count        i_bad_frames
);

    // Stalled result stays up
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid)
        else $error("result beat dropped while stalled");

    // Input stalls only behind an untaken result
    a_rx_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_rx_ready |-> i_res_valid && !i_res_ready)
        else $error("input stalled with no result pending");

    // New result comes from a byte accepted in the previous cycle
    a_res_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(i_res_valid) |-> $past(i_rx_valid && i_rx_ready))
        else $error("result without input beat");

    // Good frame bumps good total only
    a_good_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(i_res_valid) && i_checksum_ok |->
            (i_good_frames == $past(i_good_frames) + 32'd1) && $stable(i_bad_frames))
        else $error("good frame total mismatch");

    // Totals hold between results
    a_cnt_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$rose(i_res_valid) && !(i_res_valid && $past(i_res_ready))
            |-> $stable(i_good_frames) && $stable(i_bad_frames))
        else $error("frame totals moved without a result");

endmodule

bind imu_angle_frame_parser_unit iafp_checker u_iafp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_rx_valid    (i_rx.valid),
    .i_rx_ready    (i_rx.ready),
    .i_res_valid   (o_res.valid),
    .i_res_ready   (o_res.ready),
    .i_checksum_ok (o_res.checksum_ok),
    .i_good_frames (o_res.good_frames),
    .i_bad_frames  (o_res.bad_frames)
);
